>>> rtl/asfr_pkg.sv
// ----------------------------------------------------------------------------
// asfr_pkg
// Shared constants and types for the addressed serial frame receiver core.
// ----------------------------------------------------------------------------
`default_nettype none

package asfr_pkg;

   localparam int BUF_DEPTH_DEF = 16;
   localparam int FRAME_LEN_DEF = 5;
   localparam int CHECK_POS_DEF = 3;

   localparam logic [7:0] CH_NL  = 8'h0A;
   localparam logic [7:0] CH_W   = 8'h57;
   localparam logic [7:0] CH_S   = 8'h53;
   localparam logic [7:0] CH_ONE = 8'h31;

   localparam logic [7:0] STATION_ADDR_RST = 8'h01;

   localparam logic REG_STATION_ADDR = 1'b0;

   typedef enum logic [2:0] {
      ST_STORED   = 3'd0,
      ST_EXECUTED = 3'd1,
      ST_CSUM_ERR = 3'd2,
      ST_ADDR_ERR = 3'd3,
      ST_OVERFLOW = 3'd4,
      ST_OVERRUN  = 3'd5
   } status_type;

   typedef struct packed {
      logic       done;
      status_type status;
      logic       exec;
   } eval_type;

endpackage

`default_nettype wire

>>> rtl/addressed_serial_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// addressed_serial_frame_receiver_core
// Frame store, XOR checksum and address check, relay and position commands.
// ----------------------------------------------------------------------------
// Pipeline: each result passes the input stage and command stage registers.
// Throughput: one byte beat per cycle unless a held result stalls the input; the frame
// memory is written on beats with room, its two read ports fetch cmd and arg on newline.
// Reset clears the byte count, running XOR, relay, position and the pipeline;
// the frame memory keeps its contents, the station address returns to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module addressed_serial_frame_receiver_core #(
   parameter int BUF_DEPTH = asfr_pkg::BUF_DEPTH_DEF,
   parameter int FRAME_LEN = asfr_pkg::FRAME_LEN_DEF,
   parameter int CHECK_POS = asfr_pkg::CHECK_POS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] overrun
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [0] relay_out, [3:1] position_out, [7:4] zero
   output logic             rsp_tlast,   // frame_done
   output logic [2:0]       rsp_tuser,   // [2:0] status
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int CW      = $clog2(BUF_DEPTH + 1);
   localparam int AW      = $clog2(BUF_DEPTH);
   localparam int CHK_IDX = CHECK_POS % BUF_DEPTH;

   logic [7:0]  frame_store_mem [BUF_DEPTH];

   logic [7:0]  station_addr_ff;
   logic [CW-1:0] count_ff, count_in, count_stored;
   logic [7:0]  xor_ff, xor_in, xor_stored;
   logic [7:0]  byte0_ff, byte0_in;
   logic [7:0]  check_ff, check_in;
   logic [7:0]  cmd_ff, arg_ff;

   logic        s1_valid_ff, s1_valid_in;
   asfr_pkg::eval_type s1_ff, s1_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_done_ff, out_done_in;
   asfr_pkg::status_type out_status_ff, out_status_in;
   logic        relay_ff, relay_in;
   logic [2:0]  position_ff, position_in;

   logic        accept, stored, ovr, overflow, eval, clr, s1_adv;
   logic [7:0]  rx;
   logic [7:0]  arg_off;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == asfr_pkg::REG_STATION_ADDR) ?
                       {24'd0, station_addr_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         station_addr_ff <= asfr_pkg::STATION_ADDR_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == asfr_pkg::REG_STATION_ADDR) begin
         station_addr_ff <= csr_pwdata[7:0];
      end
   end

   // input stage
   assign s1_adv     = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;
   assign rx         = req_tdata;
   assign ovr        = req_tuser;

   always_comb begin
      stored       = count_ff < CW'(BUF_DEPTH);
      count_stored = count_ff + CW'(stored);
      xor_stored   = xor_ff;
      if (stored && count_ff >= CW'(1) && 32'(count_ff) < CHECK_POS) begin
         xor_stored = xor_ff ^ rx;
      end
      byte0_in = (stored && count_ff == '0) ? rx : byte0_ff;
      check_in = (stored && 32'(count_ff) == CHK_IDX) ? rx : check_ff;

      overflow = !ovr && 32'(count_stored) >= BUF_DEPTH;
      eval     = !ovr && !overflow && rx == asfr_pkg::CH_NL &&
                 32'(count_stored) == FRAME_LEN;
      clr      = overflow || eval;

      count_in = clr ? '0 : count_stored;
      xor_in   = clr ? 8'd0 : xor_stored;

      s1_in.done   = clr;
      s1_in.exec   = 1'b0;
      s1_in.status = asfr_pkg::ST_STORED;
      if (ovr) begin
         s1_in.status = asfr_pkg::ST_OVERRUN;
      end else if (overflow) begin
         s1_in.status = asfr_pkg::ST_OVERFLOW;
      end else if (eval) begin
         if (xor_stored != check_in) begin
            s1_in.status = asfr_pkg::ST_CSUM_ERR;
         end else if (byte0_in != station_addr_ff) begin
            s1_in.status = asfr_pkg::ST_ADDR_ERR;
         end else begin
            s1_in.status = asfr_pkg::ST_EXECUTED;
            s1_in.exec   = 1'b1;
         end
      end

      s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (accept && stored) begin
         frame_store_mem[count_ff[AW-1:0]] <= rx;
      end
      if (accept && eval) begin
         cmd_ff <= frame_store_mem[AW'(1)];
         arg_ff <= frame_store_mem[AW'(2)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         xor_ff      <= 8'd0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            count_ff <= count_in;
            xor_ff   <= xor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte0_ff <= byte0_in;
         check_ff <= check_in;
         s1_ff    <= s1_in;
      end
   end

   // command stage
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_done_in   = out_done_ff;
      out_status_in = out_status_ff;
      relay_in      = relay_ff;
      position_in   = position_ff;
      arg_off       = arg_ff - asfr_pkg::CH_ONE;
      if (s1_valid_ff && s1_adv) begin
         out_valid_in  = 1'b1;
         out_done_in   = s1_ff.done;
         out_status_in = s1_ff.status;
         if (s1_ff.exec) begin
            if (cmd_ff == asfr_pkg::CH_W) begin
               relay_in = (arg_ff == asfr_pkg::CH_ONE);
            end else if (cmd_ff == asfr_pkg::CH_S && arg_off < 8'd8) begin
               position_in = arg_off[2:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         relay_ff     <= 1'b0;
         position_ff  <= 3'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         relay_ff     <= relay_in;
         position_ff  <= position_in;
      end
   end

   always_ff @(posedge clock) begin
      out_done_ff   <= out_done_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_done_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {4'd0, position_ff, relay_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= BUF_DEPTH)
      else $error("byte count beyond store depth");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled with room in the pipeline");

   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      (accept && clr) |=> (count_ff == '0 && xor_ff == 8'd0))
      else $error("frame not cleared after evaluation or overflow");

   a_done_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |->
         (rsp_tuser == asfr_pkg::ST_EXECUTED || rsp_tuser == asfr_pkg::ST_CSUM_ERR ||
          rsp_tuser == asfr_pkg::ST_ADDR_ERR || rsp_tuser == asfr_pkg::ST_OVERFLOW))
      else $error("frame done with a non-final status");
`endif

endmodule

`default_nettype wire

>>> bench/addressed_serial_frame_receiver_core_checker.sv
// ----------------------------------------------------------------------------
// addressed_serial_frame_receiver_core_checker
// Watches the byte, result and register ports of the frame receiver. It keeps
// its own copy of the frame store, running XOR, relay, position and station
// address, and works out the result of every accepted byte beat. Each result
// beat is compared field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module addressed_serial_frame_receiver_core_checker
   import asfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] overrun
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [0] relay_out, [3:1] position_out, [7:4] zero
   input  logic        rsp_tlast,   // frame_done
   input  logic [2:0]  rsp_tuser,   // [2:0] status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH = BUF_DEPTH_DEF;
   localparam int FRAME_BYTES = FRAME_LEN_DEF;
   localparam int CSUM_INDEX  = CHECK_POS_DEF;
   localparam logic [2:0] CSR_STATION_ADDR = 3'(REG_STATION_ADDR) << 2;

   typedef struct packed {
      logic       done;
      status_type status;
      logic       relay;
      logic [2:0] position;
   } rx_result_t;

   logic [7:0] frame_mem [STORE_DEPTH];
   int         fill;
   logic [7:0] csum;
   logic       relay_q;
   logic [2:0] position_q;
   logic [7:0] station;
   rx_result_t due_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      rx_result_t want;
      rx_result_t got;
      logic [7:0] rx_byte;
      logic [7:0] arg;
      if (reset) begin
         fill       = 0;
         csum       = '0;
         relay_q    = 1'b0;
         position_q = '0;
         station    = STATION_ADDR_RST;
         foreach (frame_mem[i]) frame_mem[i] = '0;
         due_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tlast, status_type'(rsp_tuser), rsp_tdata[0], rsp_tdata[3:1]};
            if (due_q.size() == 0) begin
               $display("%0t: unexpected beat: done=%0b status=%0d relay=%0b pos=%0d",
                        $time, got.done, got.status, got.relay, got.position);
               fail_count++;
            end else begin
               want = due_q.pop_front();
               if (got.done !== want.done || got.status !== want.status ||
                   got.relay !== want.relay || got.position !== want.position) begin
                  $display("%0t: done/status/relay/pos expected %0b %0d %0b %0d, got %0b %0d %0b %0d",
                           $time, want.done, want.status, want.relay, want.position,
                           got.done, got.status, got.relay, got.position);
                  fail_count++;
               end
            end
         end

         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == CSR_STATION_ADDR)
            station = csr_pwdata[7:0];

         if (req_tvalid && req_tready) begin
            rx_byte     = req_tdata;
            want.done   = 1'b0;
            want.status = ST_STORED;
            if (fill < STORE_DEPTH) begin
               frame_mem[fill] = rx_byte;
               if (fill >= 1 && fill < CSUM_INDEX) csum ^= rx_byte;
               fill++;
            end
            if (req_tuser) begin
               want.status = ST_OVERRUN;
            end else if (fill >= STORE_DEPTH) begin
               fill = 0;
               csum = '0;
               foreach (frame_mem[i]) frame_mem[i] = '0;
               want.done   = 1'b1;
               want.status = ST_OVERFLOW;
            end else if (rx_byte == CH_NL && fill == FRAME_BYTES) begin
               want.done = 1'b1;
               if (csum != frame_mem[CSUM_INDEX % STORE_DEPTH]) begin
                  want.status = ST_CSUM_ERR;
               end else if (frame_mem[0] != station) begin
                  want.status = ST_ADDR_ERR;
               end else begin
                  want.status = ST_EXECUTED;
                  arg = frame_mem[2 % STORE_DEPTH];
                  if (frame_mem[1 % STORE_DEPTH] == CH_W) begin
                     relay_q = (arg == CH_ONE);
                  end else if (frame_mem[1 % STORE_DEPTH] == CH_S) begin
                     if (arg >= CH_ONE && arg <= CH_ONE + 7)
                        position_q = 3'(arg - CH_ONE);
                  end
               end
               fill = 0;
               csum = '0;
            end
            want.relay    = relay_q;
            want.position = position_q;
            due_q.push_back(want);
         end
      end
      pending = due_q.size();
   end

endmodule

>>> bench/addressed_serial_frame_receiver_core_tb.sv
// ----------------------------------------------------------------------------
// addressed_serial_frame_receiver_core_tb
// Feeds serial byte beats to the frame receiver: a short directed run of
// good, bad-checksum, wrong-address, overrun and wrong-length frames, then
// phases of random frames, noise and store overflows under several station
// addresses, with random pacing on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module addressed_serial_frame_receiver_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import asfr_pkg::*;

   localparam int LONG_HOLD   = 200;
   localparam int PHASE_BEATS = 241;
   localparam logic [2:0] CSR_STATION_ADDR = 3'(REG_STATION_ADDR) << 2;

   typedef enum {PACE_FULL, PACE_NONE, PACE_SPARSE} pace_t;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] rx_byte
   logic        req_tuser;   // [0] overrun
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [0] relay_out, [3:1] position_out, [7:4] zero
   logic        rsp_tlast;   // frame_done
   logic [2:0]  rsp_tuser;   // [2:0] status
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending;

   int          fill;
   int          sent;
   int          tx_left;
   pace_t       tx_pace;
   logic        rush;
   logic        rx_hold_req;
   logic [7:0]  station;

   addressed_serial_frame_receiver_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   addressed_serial_frame_receiver_core_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int draw_wait(pace_t pace);
      case (pace)
         PACE_NONE:   return 0;
         PACE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
         default:     return $urandom_range(0, 11);
      endcase
   endfunction

   function automatic logic [7:0] filler_byte();
      logic [7:0] b;
      b = 8'($urandom);
      return (b == CH_NL) ? 8'hFF : b;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic ovr);
      int gap;
      if (tx_left == 0) begin
         tx_pace = pace_t'($urandom_range(0, 2));
         tx_left = 50;
      end
      tx_left--;
      gap = rush ? 0 : draw_wait(tx_pace);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tuser  = ovr;
      do @(posedge clock); while (!req_tready);
      // track the frame fill so that frames can be lined up
      if (fill < BUF_DEPTH_DEF) fill++;
      if (!ovr && fill >= BUF_DEPTH_DEF) fill = 0;
      else if (!ovr && b == CH_NL && fill == FRAME_LEN_DEF) fill = 0;
      sent++;
   endtask

   task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
                             input logic [7:0] arg, input logic [7:0] check,
                             input int ovr_at);
      send_byte(addr, ovr_at == 0);
      send_byte(cmd, ovr_at == 1);
      send_byte(arg, ovr_at == 2);
      send_byte(check, ovr_at == 3);
      send_byte(CH_NL, ovr_at == 4);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      wait (pending == 0);
   endtask

   task automatic csr_write(input logic [7:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = CSR_STATION_ADDR;
      csr_pwdata  = {24'($urandom), value};
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic run_sequence();
      int         r;
      int         n;
      logic [7:0] addr;
      logic [7:0] cmd;
      logic [7:0] arg;
      logic [7:0] check;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         while (fill != 0) send_byte(filler_byte(), 1'b0);
         addr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : station;
         n = $urandom_range(0, 9);
         if (n < 4) begin
            cmd = CH_W;
            case ($urandom_range(0, 2))
               0:       arg = CH_ONE;
               1:       arg = CH_ONE - 8'd1;
               default: arg = 8'($urandom);
            endcase
         end else if (n < 8) begin
            cmd = CH_S;
            arg = ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                  8'(CH_ONE - 1 + $urandom_range(0, 9));
         end else begin
            cmd = 8'($urandom);
            arg = 8'($urandom);
         end
         check = ($urandom_range(0, 6) == 0) ? 8'($urandom) : cmd ^ arg;
         send_frame(addr, cmd, arg, check,
                    ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4) : -1);
      end else if (r < 80) begin
         n = $urandom_range(1, 20);
         repeat (n)
            send_byte(($urandom_range(0, 3) == 0) ? CH_NL : 8'($urandom),
                      $urandom_range(0, 9) == 0);
      end else if (r < 88) begin
         if ($urandom_range(0, 1) == 0) begin
            repeat (BUF_DEPTH_DEF) send_byte(filler_byte(), 1'b0);
         end else begin
            repeat (BUF_DEPTH_DEF + 1) send_byte(8'($urandom), 1'b1);
            send_byte(8'($urandom), 1'b0);
         end
      end else begin
         while (fill != 0) send_byte(filler_byte(), 1'b0);
         send_byte(station, 1'b0);
         send_byte(CH_W, 1'b0);
         if ($urandom_range(0, 1) == 0) begin
            send_byte(CH_ONE, 1'b0);
            send_byte(CH_W ^ CH_ONE, 1'b0);
            send_byte(8'($urandom), 1'b0);
         end
         send_byte(CH_NL, 1'b0);
      end
   endtask

   initial begin
      #20_000_000;
      $display("addressed_serial_frame_receiver_core: mismatch");
      $finish;
   end

   initial begin
      int    stall;
      int    left;
      pace_t pace;
      rsp_tready = 1'b0;
      left       = 0;
      pace       = PACE_FULL;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (rx_hold_req) begin
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            rx_hold_req = 1'b0;
         end
         if (left == 0) begin
            pace = pace_t'($urandom_range(0, 2));
            left = 64;
         end
         left--;
         stall = draw_wait(pace);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      int phase_start;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      fill        = 0;
      sent        = 0;
      tx_left     = 0;
      tx_pace     = PACE_FULL;
      rush        = 1'b0;
      rx_hold_req = 1'b0;
      station     = STATION_ADDR_RST;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_frame(STATION_ADDR_RST, CH_W, CH_ONE, CH_W ^ CH_ONE, -1);
      send_frame(STATION_ADDR_RST, CH_S, CH_ONE + 8'd7, CH_S ^ (CH_ONE + 8'd7), -1);
      send_frame(STATION_ADDR_RST, CH_W, CH_ONE - 8'd1, 8'h00, -1);
      send_frame(STATION_ADDR_RST + 8'd1, CH_W, CH_ONE - 8'd1,
                 CH_W ^ (CH_ONE - 8'd1), -1);
      send_byte(8'hFF, 1'b1);
      send_byte(CH_NL, 1'b0);
      send_byte(8'h00, 1'b0);

      for (int phase = 0; phase < 8; phase++) begin
         drain();
         case (phase)
            0:       station = STATION_ADDR_RST;
            1:       station = 8'h00;
            2:       station = 8'hFF;
            3:       station = CH_NL;
            default: station = 8'($urandom);
         endcase
         csr_write(station);
         phase_start = sent;
         if (phase == 4) begin
            rush        = 1'b1;
            rx_hold_req = 1'b1;
         end
         while (sent < 23 + (phase + 1) * PHASE_BEATS) begin
            if (sent - phase_start > 80) rush = 1'b0;
            run_sequence();
         end
      end

      drain();
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("addressed_serial_frame_receiver_core: match");
      end else begin
         $display("addressed_serial_frame_receiver_core: mismatch");
      end
      $finish;
   end

endmodule
